>>> hw/rtl/bpc_pkg.sv
// shared types and constants for the button press classifier
`default_nettype none

package bpc_pkg;

    localparam int unsigned NUM_BUTTONS = 6;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = CFG_W'(300);
    localparam logic [CFG_W-1:0] HOLD_MS_RST       = CFG_W'(1000);

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] double_window;
        logic [CFG_W-1:0] hold_ms;
    } t_cfg;

endpackage

`default_nettype wire

>>> hw/rtl/button_press_classifier.sv
// top level: six-button short, long and double press classifier
//
// One input beat is a poll: a millisecond timestamp and six active-high
// button levels. Each accepted beat yields exactly one output beat that
// carries one event code per button (none, short, long, double press).
// Both channels use valid/ready; thresholds are written through the plain
// configuration port (index 0 double-press window, index 1 long-press time)
// only while the block is idle, a rule for the user that the block does not
// enforce. An accepted beat is held in the input register, and the
// per-button classification loads the output register, where o_out_valid
// rises, once the output slot is free or being drained. Throughput is one
// beat per cycle while the receiver is ready; the input side keeps taking
// beats while an output beat waits, until both registers are full.
// When the receiver stalls, the output beat holds and the input register
// fills, after which o_in_ready drops; no beat is lost or repeated.
// Synchronous reset clears all button state and both valid flags, and loads
// the thresholds with 300 ms and 1000 ms.
`default_nettype none

module button_press_classifier
    import bpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [TIME_W-1:0]    i_time_ms,
    input  wire logic                 i_up_pressed,
    input  wire logic                 i_down_pressed,
    input  wire logic                 i_left_pressed,
    input  wire logic                 i_right_pressed,
    input  wire logic                 i_back_pressed,
    input  wire logic                 i_ok_pressed,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_up_event,
    output logic [1:0]                o_down_event,
    output logic [1:0]                o_left_event,
    output logic [1:0]                o_right_event,
    output logic [1:0]                o_back_event,
    output logic [1:0]                o_ok_event
);

    t_cfg                   r_cfg;
    logic                   r_in_vld;
    logic [TIME_W-1:0]      r_time;
    logic [NUM_BUTTONS-1:0] r_pressed;
    logic                   r_out_vld;
    t_event                 r_events [NUM_BUTTONS];
    t_event                 n_events [NUM_BUTTONS];
    logic                   advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_window <= DOUBLE_WINDOW_RST;
            r_cfg.hold_ms       <= HOLD_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DOUBLE_WINDOW: r_cfg.double_window <= i_cfg_data;
                REG_HOLD_MS:       r_cfg.hold_ms       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: process when the output slot is free or being drained
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_time    <= i_time_ms;
            r_pressed <= {i_ok_pressed, i_back_pressed, i_right_pressed,
                          i_left_pressed, i_down_pressed, i_up_pressed};
        end
    end

    // per-button classifiers
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
        bpc_button u_btn (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (advance),
            .i_pressed (r_pressed[b]),
            .i_now     (r_time),
            .i_cfg     (r_cfg),
            .o_event   (n_events[b])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_events <= n_events;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_up_event    = r_events[0];
    assign o_down_event  = r_events[1];
    assign o_left_event  = r_events[2];
    assign o_right_event = r_events[3];
    assign o_back_event  = r_events[4];
    assign o_ok_event    = r_events[5];

    // a waiting output beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // a waiting output beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable({o_ok_event, o_back_event,
            o_right_event, o_left_event, o_down_event, o_up_event}))
        else $error("output payload changed while stalled");

    // both registers full and stalled blocks the input
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted with both registers full");

endmodule

`default_nettype wire

>>> hw/rtl/bpc_button.sv
// per-button press state and event classification
`default_nettype none

module bpc_button
    import bpc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_pressed,
    input  wire logic [TIME_W-1:0] i_now,
    input  wire t_cfg              i_cfg,
    output t_event                 o_event
);

    logic              r_held;
    logic              r_pend;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_last;

    logic              n_held;
    logic              n_pend;
    logic [TIME_W-1:0] n_start;
    logic [TIME_W-1:0] n_last;

    logic [TIME_W-1:0] d_last;
    logic [TIME_W-1:0] d_start;
    logic              rise;
    logic              fall;
    logic              is_double;
    logic              under_long;
    logic              long_zero;

    // wrapped time differences and threshold compares
    assign d_last     = i_now - r_last;
    assign d_start    = i_now - r_start;
    assign rise       = i_pressed && !r_held;
    assign fall       = !i_pressed && r_held;
    assign is_double  = d_last <= TIME_W'(i_cfg.double_window);
    assign under_long = d_start < TIME_W'(i_cfg.hold_ms);
    assign long_zero  = i_cfg.hold_ms == '0;

    // next state and event for this beat
    always_comb begin
        n_held  = r_held;
        n_pend  = r_pend;
        n_start = r_start;
        n_last  = r_last;
        o_event = EV_NONE;
        if (rise) begin
            n_held  = 1'b1;
            n_start = i_now;
            n_last  = i_now;
            if (is_double) begin
                o_event = EV_DOUBLE;
                n_pend  = 1'b0;
            end else if (long_zero) begin
                // zero hold time already met on the press itself
                o_event = EV_LONG;
                n_pend  = 1'b0;
            end else begin
                n_pend  = 1'b1;
            end
        end else if (fall) begin
            n_held = 1'b0;
            n_pend = 1'b0;
            if (r_pend && under_long) begin
                o_event = EV_SHORT;
            end
        end else if (i_pressed && r_pend && !under_long) begin
            o_event = EV_LONG;
            n_pend  = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_pend  <= 1'b0;
            r_start <= '0;
            r_last  <= '0;
        end else if (i_en) begin
            r_held  <= n_held;
            r_pend  <= n_pend;
            r_start <= n_start;
            r_last  <= n_last;
        end
    end

    // a pending single press only exists while the button is held
    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_held)
        else $error("pending press without held latch");

    // a processed release always clears the latch and the pending flag
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_pressed) |=> (!r_held && !r_pend))
        else $error("release did not clear button state");

    // state only moves when a beat is processed
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_held) && $stable(r_pend) && $stable(r_start)))
        else $error("button state changed without a beat");

endmodule

`default_nettype wire
